>>> sv/ght_pkg.sv
// types and constants shared by the generational handle table
`default_nettype none
package ght_pkg;

  // table geometry
  localparam int NUM_SLOTS = 256;
  localparam int IDX_W     = $clog2(NUM_SLOTS);
  localparam int CNT_W     = IDX_W + 1;
  localparam int GEN_W     = 16;
  localparam int PAY_W     = 32;

  // request kinds
  typedef enum logic [1:0] {
    KIND_CREATE  = 2'd0,
    KIND_UPDATE  = 2'd1,
    KIND_RELEASE = 2'd2,
    KIND_COPY    = 2'd3
  } kind_t;

  // response status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  // request transaction
  typedef struct packed {
    kind_t        kind;
    logic [8:0]   handle_index;
    logic [15:0]  handle_generation;
    logic [31:0]  payload_in;
  } in_t;

  // response transaction
  typedef struct packed {
    status_t      status;
    logic [7:0]   result_index;
    logic [15:0]  result_generation;
    logic         newly_allocated;
    logic [31:0]  payload_out;
  } out_t;

  // one slot memory word
  typedef struct packed {
    logic             allocated;
    logic [GEN_W-1:0] generation;
    logic [PAY_W-1:0] payload;
  } slot_word_t;

  // request sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_ALLOC
  } state_t;

endpackage
`default_nettype wire

>>> sv/generational_handle_table_core.sv
// generational handle table: slot memory, free stack memory and request sequencer
//
// Every request passes the idle state, which takes it and reads the slot and the
// free stack top, and the lookup state, which decides (and writes back). An
// allocation then passes the allocation state, which uses one more slot read to
// fetch the generation of the slot that is allocated. A request is taken only
// while the sequencer is idle and the response register is empty or being drained
// in the same cycle. The slot memory holds allocated flag, generation and payload
// per slot; a per-slot written bit, cleared at reset, makes never-written slots
// read as free with generation zero, so no clearing pass is needed after reset.
`default_nettype none
module generational_handle_table_core
  import ght_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_data
);

  localparam logic [CNT_W-1:0] SLOT_LIMIT = CNT_W'(NUM_SLOTS);

  // sequencer and bookkeeping registers
  state_t           state_r, state_nxt;
  in_t              req_r, req_nxt;
  logic [IDX_W-1:0] slot_r, slot_nxt;
  logic [CNT_W-1:0] free_count_r, free_count_nxt;
  logic [CNT_W-1:0] high_water_r, high_water_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_data_r, out_nxt;

  // memories and their ports
  slot_word_t       slot_mem [NUM_SLOTS];
  logic [IDX_W-1:0] stack_mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] written_r;
  slot_word_t       slot_rd_r;
  logic             written_rd_r;
  logic [IDX_W-1:0] stack_rd_r;

  logic             slot_we;
  logic [IDX_W-1:0] slot_waddr, slot_raddr;
  slot_word_t       slot_wdata;
  logic             stack_we;
  logic [IDX_W-1:0] stack_waddr, stack_raddr;
  logic [IDX_W-1:0] stack_wdata;

  logic             in_acc;
  logic             rd_alloc;
  logic [GEN_W-1:0] rd_gen;
  logic             handle_ok;

  // handshake
  assign in_stall  = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // slot read data, never-written slots look free with generation zero
  assign rd_alloc  = written_rd_r && slot_rd_r.allocated;
  assign rd_gen    = written_rd_r ? slot_rd_r.generation : '0;
  assign handle_ok = (req_r.handle_index < high_water_r) &&
                     (req_r.handle_index < SLOT_LIMIT) && rd_alloc &&
                     (rd_gen == req_r.handle_generation[GEN_W-1:0]);

  // slot memory
  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    slot_rd_r <= slot_mem[slot_raddr];
  end

  // free stack memory
  always_ff @(posedge clk) begin
    if (stack_we) begin
      stack_mem[stack_waddr] <= stack_wdata;
    end
    stack_rd_r <= stack_mem[stack_raddr];
  end

  // per-slot written bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r    <= '0;
      written_rd_r <= 1'b0;
    end else begin
      if (slot_we) begin
        written_r[slot_waddr] <= 1'b1;
      end
      written_rd_r <= written_r[slot_raddr];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      free_count_r <= '0;
      high_water_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      free_count_r <= free_count_nxt;
      high_water_r <= high_water_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    slot_r     <= slot_nxt;
    out_data_r <= out_nxt;
  end

  // sequencer next state and memory controls
  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    slot_nxt       = slot_r;
    free_count_nxt = free_count_r;
    high_water_nxt = high_water_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_nxt        = out_data_r;
    slot_raddr     = req_r.handle_index[IDX_W-1:0];
    slot_we        = 1'b0;
    slot_waddr     = req_r.handle_index[IDX_W-1:0];
    slot_wdata     = slot_rd_r;
    stack_we       = 1'b0;
    stack_waddr    = free_count_r[IDX_W-1:0];
    stack_wdata    = req_r.handle_index[IDX_W-1:0];
    stack_raddr    = free_count_r[IDX_W-1:0] - IDX_W'(1);

    unique case (state_r)
      S_IDLE: begin
        // take a transaction and read its slot and the stack top
        if (in_acc) begin
          req_nxt    = in_data;
          slot_raddr = in_data.handle_index[IDX_W-1:0];
          state_nxt  = S_LOOK;
        end
      end

      S_LOOK: begin
        out_nxt   = '{status: ST_OK, result_index: '0, result_generation: '0,
                      newly_allocated: 1'b0, payload_out: '0};
        state_nxt = S_IDLE;
        priority if (req_r.kind == KIND_UPDATE && handle_ok) begin
          // overwrite payload of a live slot
          slot_we                   = 1'b1;
          slot_wdata.allocated      = 1'b1;
          slot_wdata.generation     = rd_gen;
          slot_wdata.payload        = req_r.payload_in;
          out_nxt.result_index      = req_r.handle_index[IDX_W-1:0];
          out_nxt.result_generation = req_r.handle_generation;
          out_valid_nxt             = 1'b1;
        end else if (req_r.kind == KIND_CREATE || req_r.kind == KIND_UPDATE) begin
          // pick a slot: stack top first, then the next never-used one
          priority if (free_count_r != '0) begin
            slot_nxt       = stack_rd_r;
            slot_raddr     = stack_rd_r;
            free_count_nxt = free_count_r - CNT_W'(1);
            state_nxt      = S_ALLOC;
          end else if (high_water_r < SLOT_LIMIT) begin
            slot_nxt       = high_water_r[IDX_W-1:0];
            slot_raddr     = high_water_r[IDX_W-1:0];
            high_water_nxt = high_water_r + CNT_W'(1);
            state_nxt      = S_ALLOC;
          end else begin
            out_nxt.status = ST_FULL;
            out_valid_nxt  = 1'b1;
          end
        end else if (!handle_ok) begin
          out_nxt.status = ST_INVALID;
          out_valid_nxt  = 1'b1;
        end else if (req_r.kind == KIND_RELEASE) begin
          // free slot, bump generation, push onto the stack
          slot_we               = 1'b1;
          slot_wdata.allocated  = 1'b0;
          slot_wdata.generation = rd_gen + GEN_W'(1);
          slot_wdata.payload    = '0;
          if (free_count_r < SLOT_LIMIT) begin
            stack_we       = 1'b1;
            free_count_nxt = free_count_r + CNT_W'(1);
          end
          out_valid_nxt = 1'b1;
        end else begin
          // copy out the stored word
          out_nxt.result_index      = req_r.handle_index[IDX_W-1:0];
          out_nxt.result_generation = req_r.handle_generation;
          out_nxt.payload_out       = slot_rd_r.payload;
          out_valid_nxt             = 1'b1;
        end
      end

      S_ALLOC: begin
        // mark the chosen slot allocated and return its handle
        slot_we               = 1'b1;
        slot_waddr            = slot_r;
        slot_wdata.allocated  = 1'b1;
        slot_wdata.generation = rd_gen;
        slot_wdata.payload    = req_r.payload_in;
        out_nxt = '{status: ST_OK, result_index: slot_r, result_generation: rd_gen,
                    newly_allocated: 1'b1, payload_out: '0};
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // free slots never outnumber the slots handed out so far
  a_free_below_hw: assert property (@(posedge clk) disable iff (!rst_n)
    free_count_r <= high_water_r)
    else $error("free count above high-water count");

  // high-water count stays within the table
  a_hw_limit: assert property (@(posedge clk) disable iff (!rst_n)
    high_water_r <= SLOT_LIMIT)
    else $error("high-water count beyond table size");

  // a full response is only given when no slot is left
  a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status == ST_FULL) |->
      (high_water_r == SLOT_LIMIT && free_count_r == '0))
    else $error("table full reported with slots left");

  // the allocation step always follows the lookup step
  a_alloc_after_look: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ALLOC) |-> ($past(state_r) == S_LOOK))
    else $error("allocation step without lookup");

endmodule
`default_nettype wire
